// ===== rtl/core/byte_to_14bit_unit_encoder_unit_macros.svh =====
// Assertion macros for the byte to 14-bit unit encoder.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef BYTE_TO_14BIT_UNIT_ENCODER_UNIT_MACROS_SVH
`define BYTE_TO_14BIT_UNIT_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B14E_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define B14E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/b14e_pkg.sv =====
// Shared types and constants for the byte to 14-bit unit encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package b14e_pkg;

  localparam int unsigned GroupBits  = 14;
  localparam int unsigned PendBits   = 13;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned UnitBits   = 16;
  localparam int unsigned UnitsMax   = 3;
  localparam int unsigned BlockBytes = 7;
  localparam int unsigned FifoDepth  = 4;

  localparam logic [UnitBits-1:0] DataBase = 16'h4E00;
  localparam logic [UnitBits-1:0] MarkBase = 16'h3D00;

  // Units produced by one input byte, in output order.
  typedef struct packed {
    logic [1:0]                          num;
    logic                                last;
    logic [UnitsMax-1:0][UnitBits-1:0]   unit;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/byte_to_14bit_unit_encoder_unit.sv =====
// Byte stream to 14-bit code unit encoder (top level).
// Input channel s_axis: one byte per beat in tdata, tlast on the final byte
//   of a message. Output channel m_axis: one 16-bit code unit per beat,
//   0x4E00 plus 14 stream bits, or the marker 0x3D00 plus the byte count
//   modulo 7; tlast marks the final unit of the message.
// Every 7 bytes give 4 units. A final byte whose message length is not a
//   multiple of 7 adds a zero-padded unit and the marker, so one byte can
//   cause up to 3 units.
// Throughput: one byte per cycle on the input and one unit per cycle on the
//   output while the queue is not full and the receiver is ready; the output
//   register sends one unit a cycle, so a final byte with a tail holds the output for up to 3 units.
// A byte's entry is written into the entry queue at the edge that accepts the
//   byte; its units then pass in order from the queue head into the output
//   register that drives m_axis.
// A 4-entry queue sits between front and back; when the receiver stalls it
//   fills and then s_axis_tready drops. Reset empties the queue and clears
//   the pending bits, so the next byte starts a new message.
// Depends on b14e_pkg, b14e_front, b14e_fifo, b14e_back and the macro header.
`default_nettype none

`include "byte_to_14bit_unit_encoder_unit_macros.svh"

module byte_to_14bit_unit_encoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // is_last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [15:0] code_unit
  output logic             m_axis_tlast_o    // last_unit
);

  b14e_pkg::entry_t     entry;
  b14e_pkg::entry_t     head;
  b14e_pkg::fifo_stat_t fifo_stat;
  logic                 push;
  logic                 pop;

  b14e_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .fifo_stat_i     (fifo_stat),
    .push_o          (push),
    .entry_o         (entry)
  );

  b14e_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (fifo_stat)
  );

  b14e_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .fifo_stat_i     (fifo_stat),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  `B14E_ASSERT_NOW(a_unit_range, m_axis_tvalid_o, (m_axis_tdata_o >= 16'h4E00 && m_axis_tdata_o <= 16'h8DFF) || (m_axis_tdata_o >= 16'h3D01 && m_axis_tdata_o <= 16'h3D06), "code unit out of range")
  `B14E_ASSERT_NOW(a_marker_last, m_axis_tvalid_o && m_axis_tdata_o[15:8] == 8'h3D, m_axis_tlast_o, "marker unit without tlast")
  `B14E_ASSERT_NOW(a_no_overflow, push, !fifo_stat.full, "entry pushed into full queue")
  `B14E_ASSERT_NOW(a_no_underflow, pop, !fifo_stat.empty, "entry popped from empty queue")

endmodule

`default_nettype wire

// ===== rtl/core/b14e_front.sv =====
// Front end: takes input bytes, packs the bit stream and builds unit entries.
// Depends on b14e_pkg; pushes entries into b14e_fifo.
`default_nettype none

module b14e_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                 s_axis_tlast_i,   // is_last
  input  wire b14e_pkg::fifo_stat_t fifo_stat_i,
  output logic                      push_o,
  output b14e_pkg::entry_t          entry_o
);

  localparam int unsigned AccW = b14e_pkg::PendBits + b14e_pkg::ByteBits;

  logic [b14e_pkg::PendBits-1:0] pend_q, pend_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [2:0]                    gp_q, gp_d;

  logic                          accept;
  logic [AccW-1:0]               acc;
  logic [4:0]                    cnt8;
  logic [4:0]                    cnt2;
  logic [4:0]                    sh;
  logic                          have_data;
  logic                          have_tail;
  logic [AccW-1:0]               rem;
  logic [AccW-1:0]               padded;
  logic [b14e_pkg::GroupBits-1:0] grp;
  logic [b14e_pkg::GroupBits-1:0] pad_grp;
  logic [2:0]                    gp_next;
  logic [b14e_pkg::UnitBits-1:0] data_unit;
  logic [b14e_pkg::UnitBits-1:0] pad_unit;
  logic [b14e_pkg::UnitBits-1:0] mark_unit;

  assign s_axis_tready_o = !fifo_stat_i.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    acc       = {pend_q, s_axis_tdata_i};
    cnt8      = {1'b0, cnt_q} + 5'd8;
    have_data = (cnt8 >= 5'(b14e_pkg::GroupBits));
    sh        = cnt8 - 5'(b14e_pkg::GroupBits);
    grp       = b14e_pkg::GroupBits'(acc >> sh);
    cnt2      = have_data ? sh : cnt8;
    // keep only the bits not yet sent
    rem       = acc & ((AccW'(1) << cnt2) - AccW'(1));
    padded    = rem << (5'(b14e_pkg::GroupBits) - cnt2);
    pad_grp   = padded[b14e_pkg::GroupBits-1:0];
    have_tail = s_axis_tlast_i && (cnt2 != 5'd0);
    gp_next   = (gp_q == 3'(b14e_pkg::BlockBytes - 1)) ? 3'd0 : gp_q + 3'd1;

    data_unit = b14e_pkg::DataBase + {2'b00, grp};
    pad_unit  = b14e_pkg::DataBase + {2'b00, pad_grp};
    mark_unit = b14e_pkg::MarkBase + {13'd0, gp_next};

    entry_o.last = s_axis_tlast_i;
    // a data unit when a group completes, plus a padded unit and a marker on a tail
    entry_o.num  = {1'b0, have_data} + {have_tail, 1'b0};
    if (have_data) begin
      entry_o.unit[0] = data_unit;
      entry_o.unit[1] = pad_unit;
      entry_o.unit[2] = mark_unit;
    end else begin
      entry_o.unit[0] = pad_unit;
      entry_o.unit[1] = mark_unit;
      entry_o.unit[2] = '0;
    end
    push_o = accept && (have_data || have_tail);

    pend_d = pend_q;
    cnt_d  = cnt_q;
    gp_d   = gp_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        pend_d = '0;
        cnt_d  = '0;
        gp_d   = '0;
      end else begin
        pend_d = rem[b14e_pkg::PendBits-1:0];
        cnt_d  = cnt2[3:0];
        gp_d   = gp_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
      gp_q   <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      gp_q   <= gp_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b14e_fifo.sv =====
// Short entry queue between the front and back ends of the encoder.
// Depends on b14e_pkg for the entry type and depth.
`default_nettype none

module b14e_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire b14e_pkg::entry_t     entry_i,
  input  wire logic                 pop_i,
  output b14e_pkg::entry_t          head_o,
  output b14e_pkg::fifo_stat_t      stat_o
);

  localparam int unsigned PtrW = $clog2(b14e_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(b14e_pkg::FifoDepth + 1);

  b14e_pkg::entry_t mem_q [b14e_pkg::FifoDepth];
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == CntW'(b14e_pkg::FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(b14e_pkg::FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(b14e_pkg::FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b14e_back.sv =====
// Back end: walks the units of the head entry and drives the output register.
// Depends on b14e_pkg; pops entries from b14e_fifo.
`default_nettype none

module b14e_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire b14e_pkg::entry_t     head_i,
  input  wire b14e_pkg::fifo_stat_t fifo_stat_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [15:0]               m_axis_tdata_o,   // [15:0] code_unit
  output logic                      m_axis_tlast_o    // last_unit
);

  logic [1:0]  idx_q, idx_d;
  logic        vld_q, vld_d;
  logic [15:0] data_q, data_d;
  logic        last_q, last_d;
  logic        load;
  logic        final_unit;

  assign load       = !fifo_stat_i.empty && (!vld_q || m_axis_tready_i);
  assign final_unit = (idx_q == head_i.num - 2'd1);
  assign pop_o      = load && final_unit;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    data_d = data_q;
    last_d = last_q;
    if (load) begin
      vld_d  = 1'b1;
      data_d = head_i.unit[idx_q];
      last_d = head_i.last && final_unit;
      idx_d  = final_unit ? 2'd0 : idx_q + 2'd1;
    end else if (m_axis_tready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire
